/* design/sed_pkg.sv */
// Shared constants and types for the skeleton endpoint detector.
// Holds the line store depth, field widths, pixel class layout and register indexes.
// No dependencies.
package sed_pkg;

    // Line store depth and the column counter width that follows from it.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Fixed field widths.
    localparam int ROW_W  = 12;
    localparam int CFG_W  = 12;
    localparam int PIX_W  = 8;
    localparam int CODE_W = 8;

    // Output stream packing: 1 + ROW_W + COL_W + CODE_W + 1 bits, padded to bytes.
    localparam int RES_W   = 1 + ROW_W + COL_W + CODE_W + 1;
    localparam int MDATA_W = ((RES_W + 7) / 8) * 8;

    // Pixel reference values.
    localparam logic [PIX_W-1:0] PIX_BACKGROUND = 8'd255;
    localparam logic [PIX_W-1:0] PIX_LINE       = 8'd0;

    // Two-bit pixel class: bit 0 is ink, bit 1 marks an exact zero.
    typedef struct packed {
        logic zero;
        logic ink;
    } pix_class_t;

    // One line store word: the older row above the recent row.
    typedef struct packed {
        pix_class_t older;
        pix_class_t recent;
    } line_word_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

endpackage

/* design/skeleton_endpoint_detector.sv */
// Skeleton endpoint detector over a raster pixel stream, 3x3 window.
// Depends on sed_pkg for widths, the pixel class type and register indexes.
// Rate: one pixel per clock, sustained while m_tready stays high. Each pixel is
// accepted in a cycle in which its column entry of the line store memory is
// read; stage one then takes the registered read data, updates the window,
// writes the entry back and loads the output register, from which the result
// is sent. A read that meets the write-back of the previous pixel at
// the same column is served by forwarding. The line store holds no reset and
// needs no clearing pass; entries are read for interior centres only after
// they were written.
module skeleton_endpoint_detector
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration write port.
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [sed_pkg::CFG_W-1:0]    cfg_data,
    // Pixel stream in.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sed_pkg::PIX_W-1:0]    s_tdata,  // [7:0] pixel_value
    // Result stream out.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] centre_valid, [12:1] centre_row, [23:13] centre_col,
    // [31:24] neighbour_code, [32] is_endpoint, upper bits zero
    output logic [sed_pkg::MDATA_W-1:0]  m_tdata
);

    localparam int COL_W = sed_pkg::COL_W;
    localparam int ROW_W = sed_pkg::ROW_W;

    // Configuration registers.
    logic [sed_pkg::CFG_W-1:0] width_reg;
    logic [sed_pkg::CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sed_pkg::WIDTH_RESET;
            height_reg <= sed_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (sed_pkg::cfg_index_t'(cfg_index))
                sed_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                sed_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Pipeline handshake.
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s_accept;
    logic s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    // Position counters of the next pixel.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W:0]   col_plus;
    logic [ROW_W:0]   row_plus;
    logic             col_wrap;
    logic             row_wrap;

    assign col_plus = {1'b0, col_reg} + 1'b1;
    assign row_plus = {1'b0, row_reg} + 1'b1;
    assign col_wrap = (32'(col_plus) >= 32'(sed_pkg::MAX_WIDTH))
                   || (32'(col_plus) >= 32'(width_reg));
    assign row_wrap = 32'(row_plus) >= 32'(height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_plus[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_plus[COL_W-1:0];
            end
        end
    end

    // Classify the incoming pixel.
    sed_pkg::pix_class_t in_class;

    assign in_class.ink  = (s_tdata != sed_pkg::PIX_BACKGROUND);
    assign in_class.zero = (s_tdata == sed_pkg::PIX_LINE);

    // Stage one payload: the accepted pixel and its position.
    sed_pkg::pix_class_t s1_class_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic                s1_interior_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_class_reg    <= in_class;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_interior_reg <= (32'(row_reg) >= 32'd2) && (32'(col_reg) >= 32'd2);
        end
    end

    // Line store memory, read on accept and written back as stage one leaves.
    sed_pkg::line_word_t line_mem [sed_pkg::MAX_WIDTH];
    sed_pkg::line_word_t rd_data_reg;
    sed_pkg::line_word_t wr_data;
    sed_pkg::line_word_t fwd_data_reg;
    logic                fwd_reg;
    sed_pkg::line_word_t col_word;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            rd_data_reg  <= line_mem[col_reg];
            fwd_data_reg <= wr_data;
        end
        if (s1_advance)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    // A read that coincides with a write to the same entry takes the new word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            fwd_reg <= s1_advance && (s1_col_reg == col_reg);
        end
    end

    assign col_word       = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data.older  = col_word.recent;
    assign wr_data.recent = s1_class_reg;

    // Window: the middle and right columns kept from the previous pixel.
    // Index 0 is the top row, 2 the bottom row.
    sed_pkg::pix_class_t mid_reg   [3];
    sed_pkg::pix_class_t right_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mid_reg[r]   <= '0;
                right_reg[r] <= '0;
            end
        end
        else if (s1_advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mid_reg[r] <= right_reg[r];
            end
            right_reg[0] <= col_word.older;
            right_reg[1] <= col_word.recent;
            right_reg[2] <= s1_class_reg;
        end
    end

    // Neighbour code of the shifted window; the centre is the old right middle.
    logic [sed_pkg::CODE_W-1:0] code;
    logic                       centre_zero;

    assign centre_zero = right_reg[1].zero;
    assign code = {right_reg[0].ink,     // N
                   mid_reg[0].ink,       // NW
                   mid_reg[1].ink,       // W
                   mid_reg[2].ink,       // SW
                   right_reg[2].ink,     // S
                   s1_class_reg.ink,     // SE
                   col_word.recent.ink,  // E
                   col_word.older.ink};  // NE

    // Output register.
    logic                       res_valid_reg;
    logic [ROW_W-1:0]           res_row_reg;
    logic [COL_W-1:0]           res_col_reg;
    logic [sed_pkg::CODE_W-1:0] res_code_reg;
    logic                       res_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            res_valid_reg <= s1_interior_reg;
            res_row_reg   <= s1_interior_reg ? s1_row_reg - 1'b1 : '0;
            res_col_reg   <= s1_interior_reg ? s1_col_reg - 1'b1 : '0;
            if (s1_interior_reg && centre_zero)
            begin
                res_code_reg <= code;
                res_end_reg  <= $onehot(code);
            end
            else
            begin
                res_code_reg <= '0;
                res_end_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sed_pkg::MDATA_W'({res_end_reg, res_code_reg, res_col_reg,
                                         res_row_reg, res_valid_reg});

    // Checks.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while the pipeline could move");

    a_endpoint_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_end_reg |-> res_valid_reg)
        else $error("endpoint flagged for a border centre");

    a_border_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_valid_reg |-> res_code_reg == '0)
        else $error("neighbour code set for a border centre");

    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && !col_wrap |=> col_reg == $past(col_plus[COL_W-1:0]))
        else $error("column counter did not step by one");

endmodule
